/* rtl/kcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

    // Fixed key count of the scan word
    localparam int NUM_KEYS = 4;

    // Register widths and reset values
    localparam int LONG_W = 16;
    localparam int WIN_W  = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [LONG_W-1:0] LONG_PRESS_RESET = LONG_W'(70);
    localparam logic [WIN_W-1:0]  WINDOW_RESET     = WIN_W'(20);
    localparam logic [LONG_W-1:0] DURATION_MAX     = '1;

    // Stream widths, padded to whole bytes
    localparam int S_DATA_W = ((NUM_KEYS + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * NUM_KEYS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS_TICKS    = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_DOUBLE_CLICK_WINDOW = IDX_W'(1);

    // Per-key press qualifier
    typedef enum logic [1:0] {
        STAGE_IDLE  = 2'd0,
        STAGE_FIRST = 2'd1,
        STAGE_HELD  = 2'd2
    } press_stage_t;

    typedef struct packed {
        logic [LONG_W-1:0] long_press_ticks;
        logic [WIN_W-1:0]  double_click_window;
    } cfg_t;

    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_held;
    } key_res_t;

endpackage

`default_nettype wire

/* rtl/kcc_key_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module kcc_key_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic              pressed,
    input  wire kcc_pkg::cfg_t     cfg,
    output kcc_pkg::key_res_t      res
);

    kcc_pkg::press_stage_t            stage_reg, stage_next;
    logic [kcc_pkg::LONG_W-1:0]       dur_reg, dur_next, dur_mid;
    logic                             win_open_reg, win_open_next;
    logic [kcc_pkg::WIN_W-1:0]        win_cnt_reg, win_cnt_next, win_cnt_inc;
    logic                             long_reg, long_next;
    logic                             short_release;

    assign short_release = (stage_reg == kcc_pkg::STAGE_HELD) && !pressed &&
                           (dur_reg < cfg.long_press_ticks);
    assign win_cnt_inc   = win_cnt_reg + kcc_pkg::WIN_W'(1);

    // Next state of the press qualifier
    always_comb begin
        stage_next = stage_reg;
        if (pressed) begin
            case (stage_reg)
                kcc_pkg::STAGE_IDLE:  stage_next = kcc_pkg::STAGE_FIRST;
                kcc_pkg::STAGE_FIRST: stage_next = kcc_pkg::STAGE_HELD;
                default:              stage_next = stage_reg;
            endcase
        end else if (stage_reg == kcc_pkg::STAGE_HELD) begin
            stage_next = kcc_pkg::STAGE_IDLE;
        end
    end

    // Duration, click window and long level
    always_comb begin
        dur_mid       = dur_reg;
        win_open_next = win_open_reg;
        win_cnt_next  = win_cnt_reg;
        res           = '0;
        if (pressed) begin
            if (stage_reg == kcc_pkg::STAGE_IDLE) begin
                dur_mid = '0;
            end
        end else if (stage_reg == kcc_pkg::STAGE_HELD) begin
            // Toggle the window on a short release
            if (short_release) begin
                win_open_next = !win_open_reg;
                if (!win_open_reg) begin
                    win_cnt_next = '0;
                end else begin
                    res.double_click = 1'b1;
                end
            end
        end else if (win_open_reg) begin
            // Count released ticks, close on timeout
            win_cnt_next = win_cnt_inc;
            if (win_cnt_inc >= cfg.double_click_window) begin
                res.single_click = 1'b1;
                win_open_next    = 1'b0;
            end
        end

        // Saturate the held duration
        dur_next = dur_mid;
        if (stage_next == kcc_pkg::STAGE_HELD && dur_mid != kcc_pkg::DURATION_MAX) begin
            dur_next = dur_mid + kcc_pkg::LONG_W'(1);
        end

        long_next = long_reg;
        if (!pressed) begin
            long_next = 1'b0;
        end else if (dur_next >= cfg.long_press_ticks) begin
            long_next = 1'b1;
        end
        res.long_held = long_next;
    end

    // Advance the key state on each tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= kcc_pkg::STAGE_IDLE;
            dur_reg      <= '0;
            win_open_reg <= 1'b0;
            win_cnt_reg  <= '0;
            long_reg     <= 1'b0;
        end else if (step_en) begin
            stage_reg    <= stage_next;
            dur_reg      <= dur_next;
            win_open_reg <= win_open_next;
            win_cnt_reg  <= win_cnt_next;
            long_reg     <= long_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/key_click_classifier_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Key click classifier: each request on the slave stream carries one scan tick of
// four active-low key levels; every accepted tick yields exactly one result with
// per-key single-click and double-click pulses and the long-held level. A key must
// read pressed on two ticks, not necessarily in a row, to count as held; a release
// shorter than long_press_ticks toggles a double-click window, which declares a single
// click after double_click_window released ticks. Ticks are taken one per cycle while
// the result stream does not stall; each passes the input register, then the per-key
// update logic, which writes the key state and the result register in the same cycle.
// Write the configuration port only while no tick is in flight.

module key_click_classifier_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration write port
    input  wire logic                         cfg_we,
    input  wire logic [kcc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [kcc_pkg::CFG_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [kcc_pkg::S_DATA_W-1:0] s_axis_tdata,  // [3:0] key_levels
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [kcc_pkg::M_DATA_W-1:0]      m_axis_tdata   // [3:0] single_clicks,
                                                             // [7:4] double_clicks,
                                                             // [11:8] long_held
);

    localparam int NK = kcc_pkg::NUM_KEYS;

    kcc_pkg::cfg_t              cfg_reg;
    logic                       in_valid_reg;
    logic [NK-1:0]              levels_reg;
    logic                       out_valid_reg;
    logic [NK-1:0]              single_reg, double_reg, long_reg;
    logic                       step;
    kcc_pkg::key_res_t          key_res [NK];
    logic [NK-1:0]              single_next, double_next, long_next;

    // Advance when a tick is held and the result slot is free or draining
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks    <= kcc_pkg::LONG_PRESS_RESET;
            cfg_reg.double_click_window <= kcc_pkg::WINDOW_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                kcc_pkg::CFG_LONG_PRESS_TICKS:
                    cfg_reg.long_press_ticks <= cfg_wdata[kcc_pkg::LONG_W-1:0];
                kcc_pkg::CFG_DOUBLE_CLICK_WINDOW:
                    cfg_reg.double_click_window <= cfg_wdata[kcc_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            levels_reg <= s_axis_tdata[NK-1:0];
        end
    end

    // Per-key cells
    for (genvar k = 0; k < NK; k++) begin : g_key
        kcc_key_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step_en (step),
            .pressed (!levels_reg[k]),
            .cfg     (cfg_reg),
            .res     (key_res[k])
        );
        assign single_next[k] = key_res[k].single_click;
        assign double_next[k] = key_res[k].double_click;
        assign long_next[k]   = key_res[k].long_held;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            single_reg <= single_next;
            double_reg <= double_next;
            long_reg   <= long_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = kcc_pkg::M_DATA_W'({long_reg, double_reg, single_reg});

    // A key never reports two click kinds, nor a click while long-held
    a_click_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((single_reg & double_reg) == '0))
        else $error("single and double click on one key");

    a_click_not_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((long_reg & (single_reg | double_reg)) == '0))
        else $error("click reported while key is long-held");

    // A held tick facing a stalled result blocks the input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline is full");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stepped tick always lands in the result register
    a_step_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_axis_tvalid)
        else $error("processed tick lost");

endmodule

`default_nettype wire

/* tb/sv/key_click_classifier_core_tb.sv */
`timescale 1ns / 1ps

module key_click_classifier_core_tb;

    import kcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_TICKS     = 60;
    localparam int HOLD_RELEASE   = 20;
    localparam int HOLD_LONG      = 40;

    // Unassigned register slots; writes there must leave the block unchanged
    localparam logic [IDX_W-1:0] CFG_SPARE_A = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_SPARE_B = IDX_W'(3);

    // One result word, laid out as on m_axis_tdata
    typedef struct packed {
        logic [NUM_KEYS-1:0] longs;
        logic [NUM_KEYS-1:0] doubles;
        logic [NUM_KEYS-1:0] singles;
    } clicks_t;

    typedef struct {
        logic [NUM_KEYS-1:0] levels;
        bit                  pinned;
        clicks_t             result;
    } script_row_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_W-1:0]    cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    key_click_classifier_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the key state and settings
    press_stage_t        key_stage  [NUM_KEYS];
    logic [LONG_W-1:0]   held_ticks [NUM_KEYS];
    logic                win_open   [NUM_KEYS];
    logic [WIN_W-1:0]    win_ticks  [NUM_KEYS];
    logic                long_flag  [NUM_KEYS];
    logic [LONG_W-1:0]   long_thr = LONG_PRESS_RESET;
    logic [WIN_W-1:0]    win_len  = WINDOW_RESET;

    clicks_t             click_queue[$];
    clicks_t             pin_val;
    bit                  pin_on;
    bit                  idle_on;
    int                  stall_left;
    int                  quiet_cycles;
    int                  errors;
    int                  ticks_done;
    int                  settings_done;
    int                  single_seen;
    int                  double_seen;
    int                  long_seen;

    // Per-key press script for the random part
    int                  seg_left    [NUM_KEYS];
    bit                  seg_pressed [NUM_KEYS];

    // Short opening script under the reset settings
    script_row_t directed_ticks [24] = '{
        '{4'hF, 1'b1, '{4'h0, 4'h0, 4'h0}},   // all released after reset
        '{4'h0, 1'b1, '{4'h0, 4'h0, 4'h0}},   // first pressed tick
        '{4'hF, 1'b1, '{4'h0, 4'h0, 4'h0}},   // release in first stage, stage holds
        '{4'h0, 1'b0, '0},                    // press confirmed
        '{4'hF, 1'b0, '0},                    // short release opens window
        '{4'h0, 1'b0, '0},
        '{4'h0, 1'b0, '0},
        '{4'hF, 1'b1, '{4'h0, 4'hF, 4'h0}},   // second short release: double click
        '{4'h0, 1'b0, '0},
        '{4'h0, 1'b0, '0},
        '{4'h5, 1'b0, '0},                    // keys 0 and 2 open a window
        '{4'h5, 1'b0, '0},
        '{4'h0, 1'b0, '0},                    // window paused while pressed
        '{4'h0, 1'b0, '0},
        '{4'hA, 1'b0, '0},
        '{4'h5, 1'b0, '0},
        '{4'h3, 1'b0, '0},
        '{4'hC, 1'b0, '0},
        '{4'h6, 1'b0, '0},
        '{4'h9, 1'b0, '0},
        '{4'h7, 1'b0, '0},
        '{4'hE, 1'b0, '0},
        '{4'hB, 1'b0, '0},
        '{4'hD, 1'b0, '0}
    };

    // Settings walked by the random part
    int unsigned phase_long  [8] = '{2, 0, 5, 65535, 12, 70, 1, 300};
    int unsigned phase_win   [8] = '{1, 5, 0, 255, 4, 20, 255, 7};
    int          phase_ticks [8] = '{140, 100, 120, 180, 160, 160, 120, 120};

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_stage[k]   = STAGE_IDLE;
            held_ticks[k]  = '0;
            win_open[k]    = 1'b0;
            win_ticks[k]   = '0;
            long_flag[k]   = 1'b0;
            seg_left[k]    = 0;
            seg_pressed[k] = 1'b0;
        end
    end

    // Advance the predictor by one scan tick
    function automatic clicks_t classify_tick(input logic [NUM_KEYS-1:0] levels);
        clicks_t r;
        logic    pressed;
        r = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            pressed = !levels[k];
            if (pressed) begin
                if (key_stage[k] == STAGE_IDLE) begin
                    key_stage[k]  = STAGE_FIRST;
                    held_ticks[k] = '0;
                end else if (key_stage[k] == STAGE_FIRST) begin
                    key_stage[k] = STAGE_HELD;
                end
            end else if (key_stage[k] == STAGE_HELD) begin
                // short release toggles the window, long release leaves it
                if (held_ticks[k] < long_thr) begin
                    win_open[k] = !win_open[k];
                    if (win_open[k])
                        win_ticks[k] = '0;
                    else
                        r.doubles[k] = 1'b1;
                end
                key_stage[k] = STAGE_IDLE;
            end else if (win_open[k]) begin
                win_ticks[k] = win_ticks[k] + 1'b1;
                if (win_ticks[k] >= win_len) begin
                    r.singles[k] = 1'b1;
                    win_open[k]  = 1'b0;
                end
            end

            // saturating duration
            if (key_stage[k] == STAGE_HELD && held_ticks[k] != DURATION_MAX)
                held_ticks[k] = held_ticks[k] + 1'b1;

            if (pressed) begin
                if (held_ticks[k] >= long_thr)
                    long_flag[k] = 1'b1;
            end else begin
                long_flag[k] = 1'b0;
            end
            r.longs[k] = long_flag[k];
        end
        return r;
    endfunction

    // Predict on each accepted request, check each accepted result, run the watchdog
    always @(posedge aclk) begin : monitor_blk
        clicks_t predicted;
        clicks_t want;
        clicks_t got;
        bit      moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted = classify_tick(s_axis_tdata[NUM_KEYS-1:0]);
                click_queue.push_back(pin_on ? pin_val : predicted);
                ticks_done++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got   = m_axis_tdata[3*NUM_KEYS-1:0];
                moved = 1'b1;
                if (click_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result %h with nothing expected", $time, got);
                end else begin
                    want = click_queue.pop_front();
                    if (got.singles !== want.singles || got.doubles !== want.doubles ||
                        got.longs !== want.longs) begin
                        errors++;
                        $display({"%0t: expected single=%h double=%h long=%h, ",
                                  "got single=%h double=%h long=%h"},
                                 $time, want.singles, want.doubles, want.longs,
                                 got.singles, got.doubles, got.longs);
                    end
                    single_seen += $countones(got.singles);
                    double_seen += $countones(got.doubles);
                    long_seen   += $countones(got.longs);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && aresetn && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one scan tick, with an optional idle burst first, and wait for acceptance
    task automatic send_tick(input logic [NUM_KEYS-1:0] levels, input bit pinned,
                             input clicks_t pinned_val);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pin_on  = pinned;
        pin_val = pinned_val;
        s_axis_tdata  <= S_DATA_W'(levels);
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop valid, then wait out every expected result and the DRAIN_CYCLES margin
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (click_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_LONG_PRESS_TICKS:    long_thr = data;
            CFG_DOUBLE_CLICK_WINDOW: win_len  = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Load both registers; junk in the upper window bits and the spare slots is ignored
    task automatic apply_settings(input int unsigned long_ticks, input int unsigned window);
        write_reg(CFG_LONG_PRESS_TICKS, CFG_W'(long_ticks));
        write_reg(CFG_DOUBLE_CLICK_WINDOW,
                  {8'($urandom_range(0, 255)), WIN_W'(window)});
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_W'($urandom));
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    // Mostly scripted press and release runs per key, with some raw noise
    task automatic run_random(input int count);
        logic [NUM_KEYS-1:0] levels;
        int                  short_cap;
        for (int n = 0; n < count; n++) begin
            short_cap = (long_thr > 13) ? 12 : ((long_thr > 1) ? int'(long_thr) - 1 : 1);
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (seg_left[k] == 0) begin
                    seg_pressed[k] = !seg_pressed[k];
                    if (seg_pressed[k]) begin
                        if (long_thr <= 200 && $urandom_range(0, 3) == 0)
                            seg_left[k] = int'(long_thr) + $urandom_range(1, 8);
                        else
                            seg_left[k] = $urandom_range(1, short_cap);
                    end else if (win_len == 0) begin
                        seg_left[k] = $urandom_range(1, 4);
                    end else if ($urandom_range(0, 1) == 0) begin
                        seg_left[k] = $urandom_range(1, win_len);
                    end else begin
                        seg_left[k] = $urandom_range(win_len, int'(win_len) + 4);
                    end
                end
                levels[k] = !seg_pressed[k];
                seg_left[k]--;
            end
            if ($urandom_range(0, 7) == 0)
                levels = NUM_KEYS'($urandom_range(0, 15));
            send_tick(levels, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        idle_on = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Opening script runs on the reset settings
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i].levels, directed_ticks[i].pinned,
                      directed_ticks[i].result);
        drain();

        for (int p = 0; p < 8; p++) begin
            idle_on = (p % 3 != 2);
            apply_settings(phase_long[p], phase_win[p]);
            run_random(phase_ticks[p]);
            drain();
        end

        // Hold every key well past the long threshold, then release
        idle_on = 1'b1;
        apply_settings(HOLD_LONG, 255);
        for (int i = 0; i < HOLD_TICKS; i++)
            send_tick('0, 1'b0, '0);
        for (int i = 0; i < HOLD_RELEASE; i++)
            send_tick('1, 1'b0, '0);
        drain();

        for (int p = 0; p < 3; p++) begin
            apply_settings($urandom_range(1, 40), $urandom_range(1, 30));
            run_random(70);
            drain();
        end

        // Closing stretch at full rate
        idle_on = 1'b0;
        apply_settings(8, 6);
        run_random(150);
        drain();

        $display("Sent %0d scan ticks across %0d register settings, including a long hold",
                 ticks_done, settings_done);
        $display("Observed %0d single clicks, %0d double clicks, %0d long-held key ticks",
                 single_seen, double_seen, long_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/kcc_pkg.sv
rtl/kcc_key_cell.sv
rtl/key_click_classifier_core.sv
tb/sv/key_click_classifier_core_tb.sv
